FILE: rtl/core/ataci_pkg.sv
package ataci_pkg;

    localparam int NUM_DRIVES = 4;

    // configuration register indexes
    localparam logic [2:0] CFG_PRESENT   = 3'd0;
    localparam logic [2:0] CFG_ATAPI     = 3'd1;
    localparam logic [2:0] CFG_LBA_CAP   = 3'd2;
    localparam logic [2:0] CFG_SECTORS_0 = 3'd3;
    localparam logic [2:0] CFG_SECTORS_1 = 3'd4;
    localparam logic [2:0] CFG_SECTORS_2 = 3'd5;
    localparam logic [2:0] CFG_SECTORS_3 = 3'd6;

    // result status codes
    localparam logic [1:0] STS_WRITE    = 2'd0;
    localparam logic [1:0] STS_NO_DRIVE = 2'd1;
    localparam logic [1:0] STS_RANGE    = 2'd2;
    localparam logic [1:0] STS_ATAPI    = 2'd3;

    // task-file ports and values
    localparam logic [3:0] PORT_COUNT  = 4'd2;
    localparam logic [3:0] PORT_LBA_LO = 4'd3;
    localparam logic [3:0] PORT_LBA_MD = 4'd4;
    localparam logic [3:0] PORT_LBA_HI = 4'd5;
    localparam logic [3:0] PORT_DEVSEL = 4'd6;
    localparam logic [3:0] PORT_CMD    = 4'd7;
    localparam logic [3:0] PORT_CTRL   = 4'd8;

    localparam logic [7:0] CTRL_NIEN  = 8'h02;
    localparam logic [7:0] CTRL_HOB   = 8'h80;
    localparam logic [7:0] DEVSEL_CHS = 8'hA0;
    localparam logic [7:0] DEVSEL_LBA = 8'hE0;

    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    localparam logic [31:0] LBA48_START = 32'h1000_0000;

    // chs split: lba / 63 by reciprocal multiplication over the 28 bits
    // below the lba48 threshold, exact for every such address
    localparam logic [6:0]  SECT_PER_TRACK  = 7'd63;
    localparam int          CHS_LBA_W       = 28;
    localparam logic [28:0] CHS_RECIP       = 29'd272696337;  // ceil(2^34 / 63)
    localparam int          CHS_RECIP_SHIFT = 34;
    localparam int          CHS_QUO_W       = 23;

    typedef struct packed {
        logic load;     // capture the request
        logic check;    // register check result, mode and chs quotient
        logic div_run;  // chs remainder step
        logic advance;  // move to the next register write
    } t_dp_cmd;

    typedef struct packed {
        logic need_div; // request is accepted and uses chs
        logic last;     // current result ends the request
    } t_dp_sts;

endpackage

FILE: rtl/core/ataci_ctrl.sv
module ataci_ctrl
    import ataci_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.need_div ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                o_cmd.div_run = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    o_cmd.advance = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

`ifndef SYNTHESIS
    a_load_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_CHECK)
        else $error("request capture not followed by check");
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && i_sts.last) |=> r_state == S_IDLE)
        else $error("final transfer did not return to idle");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while results pending");
`endif

endmodule

FILE: rtl/core/ataci_dp.sv
module ataci_dp
    import ataci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_direction,
    input  logic [1:0]  i_drive_index,
    input  logic [31:0] i_block_address,
    input  logic [7:0]  i_sector_count,
    output logic [1:0]  o_status,
    output logic        o_channel_sel,
    output logic [3:0]  o_port,
    output logic [7:0]  o_wdata,
    output logic        o_last
);

    typedef enum logic [1:0] {
        MODE_CHS   = 2'd0,
        MODE_LBA28 = 2'd1,
        MODE_LBA48 = 2'd2
    } t_mode;

    typedef enum logic [4:0] {
        ST_CTRL    = 5'd0,
        ST_DEVSEL  = 5'd1,
        ST_HOB0_A  = 5'd2,
        ST_HOB0_W  = 5'd3,
        ST_HOB0_B  = 5'd4,
        ST_HOB1_A  = 5'd5,
        ST_HOB1_W  = 5'd6,
        ST_HOB1_B  = 5'd7,
        ST_HOB2_A  = 5'd8,
        ST_HOB2_W  = 5'd9,
        ST_HOB2_B  = 5'd10,
        ST_HOB3_A  = 5'd11,
        ST_HOB3_W  = 5'd12,
        ST_HOB3_B  = 5'd13,
        ST_COUNT   = 5'd14,
        ST_ADDR0   = 5'd15,
        ST_ADDR1   = 5'd16,
        ST_ADDR2   = 5'd17,
        ST_COMMAND = 5'd18
    } t_step;

    logic [3:0]  r_present;
    logic [3:0]  r_atapi;
    logic [3:0]  r_lba_cap;
    logic [31:0] r_sectors [4];

    logic        r_dir;
    logic [1:0]  r_drv;
    logic [31:0] r_lba;
    logic [7:0]  r_cnt;
    logic [1:0]  r_status;
    t_mode       r_mode;
    t_step       r_step;

    logic [5:0]           r_rem;
    logic [CHS_QUO_W-1:0] r_quo;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_atapi   <= '0;
            r_lba_cap <= '0;
            for (int d = 0; d < 4; d++) begin
                r_sectors[d] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRESENT:   r_present    <= i_cfg_wdata[3:0];
                CFG_ATAPI:     r_atapi      <= i_cfg_wdata[3:0];
                CFG_LBA_CAP:   r_lba_cap    <= i_cfg_wdata[3:0];
                CFG_SECTORS_0: r_sectors[0] <= i_cfg_wdata;
                CFG_SECTORS_1: r_sectors[1] <= i_cfg_wdata;
                CFG_SECTORS_2: r_sectors[2] <= i_cfg_wdata;
                CFG_SECTORS_3: r_sectors[3] <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // request check
    logic        w_absent;
    logic        w_range_bad;
    logic [32:0] w_end;
    logic [1:0]  w_status;
    t_mode       w_mode;

    always_comb begin
        w_end       = {1'b0, r_lba} + {25'd0, r_cnt};
        w_absent    = (32'(r_drv) >= 32'(NUM_DRIVES)) || !r_present[r_drv];
        w_range_bad = w_end > {1'b0, r_sectors[r_drv]};
        if (w_absent) begin
            w_status = STS_NO_DRIVE;
        end else if (r_atapi[r_drv]) begin
            w_status = STS_ATAPI;
        end else if (w_range_bad) begin
            w_status = STS_RANGE;
        end else begin
            w_status = STS_WRITE;
        end
        if (r_lba >= LBA48_START) begin
            w_mode = MODE_LBA48;
        end else if (r_lba_cap[r_drv]) begin
            w_mode = MODE_LBA28;
        end else begin
            w_mode = MODE_CHS;
        end
    end

    // track split: quotient by reciprocal multiplication, remainder from the
    // low six bits since lba - 63 * q equals lba + q modulo 64
    logic [56:0]          w_prod;
    logic [CHS_QUO_W-1:0] w_quo;

    always_comb begin
        w_prod = 57'(r_lba[CHS_LBA_W-1:0]) * 57'(CHS_RECIP);
        w_quo  = w_prod[CHS_RECIP_SHIFT +: CHS_QUO_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dir <= i_direction;
            r_drv <= i_drive_index;
            r_lba <= i_block_address;
            r_cnt <= i_sector_count;
        end
        if (i_cmd.check) begin
            r_status <= w_status;
            r_mode   <= w_mode;
            r_quo    <= w_quo;
        end
        if (i_cmd.div_run) begin
            r_rem <= r_lba[5:0] + r_quo[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CTRL;
        end else if (i_cmd.load) begin
            r_step <= ST_CTRL;
        end else if (i_cmd.advance) begin
            if (r_step == ST_DEVSEL && r_mode != MODE_LBA48) begin
                r_step <= ST_COUNT;
            end else if (r_step != ST_COMMAND) begin
                r_step <= t_step'(r_step + 5'd1);
            end
        end
    end

    // address bytes: chs cylinder = quotient / 16, head = quotient % 16
    logic [7:0] w_a0;
    logic [7:0] w_a1;
    logic [7:0] w_a2;
    logic [3:0] w_head;
    logic [7:0] w_devsel;
    logic [7:0] w_command;

    always_comb begin
        if (r_mode == MODE_CHS) begin
            w_a0   = {2'b00, r_rem} + 8'd1;
            w_a1   = r_quo[11:4];
            w_a2   = r_quo[19:12];
            w_head = r_quo[3:0];
        end else begin
            w_a0   = r_lba[7:0];
            w_a1   = r_lba[15:8];
            w_a2   = r_lba[23:16];
            w_head = (r_mode == MODE_LBA28) ? r_lba[27:24] : 4'd0;
        end
        w_devsel = ((r_mode == MODE_CHS) ? DEVSEL_CHS : DEVSEL_LBA)
                 | {3'b000, r_drv[0], w_head};
        if (r_mode == MODE_LBA48) begin
            w_command = r_dir ? CMD_WRITE_EXT : CMD_READ_EXT;
        end else begin
            w_command = r_dir ? CMD_WRITE : CMD_READ;
        end
    end

    // result fields
    always_comb begin
        o_status      = r_status;
        o_channel_sel = r_drv[1];
        o_port        = '0;
        o_wdata       = '0;
        o_last        = 1'b0;
        if (r_status != STS_WRITE) begin
            o_last = 1'b1;
        end else begin
            case (r_step)
                ST_CTRL, ST_HOB0_B, ST_HOB1_B, ST_HOB2_B, ST_HOB3_B: begin
                    o_port  = PORT_CTRL;
                    o_wdata = CTRL_NIEN;
                end
                ST_HOB0_A, ST_HOB1_A, ST_HOB2_A, ST_HOB3_A: begin
                    o_port  = PORT_CTRL;
                    o_wdata = CTRL_HOB | CTRL_NIEN;
                end
                ST_DEVSEL: begin
                    o_port  = PORT_DEVSEL;
                    o_wdata = w_devsel;
                end
                ST_HOB0_W: o_port = PORT_COUNT;
                ST_HOB1_W: begin
                    o_port  = PORT_LBA_LO;
                    o_wdata = r_lba[31:24];
                end
                ST_HOB2_W: o_port = PORT_LBA_MD;
                ST_HOB3_W: o_port = PORT_LBA_HI;
                ST_COUNT: begin
                    o_port  = PORT_COUNT;
                    o_wdata = r_cnt;
                end
                ST_ADDR0: begin
                    o_port  = PORT_LBA_LO;
                    o_wdata = w_a0;
                end
                ST_ADDR1: begin
                    o_port  = PORT_LBA_MD;
                    o_wdata = w_a1;
                end
                ST_ADDR2: begin
                    o_port  = PORT_LBA_HI;
                    o_wdata = w_a2;
                end
                ST_COMMAND: begin
                    o_port  = PORT_CMD;
                    o_wdata = w_command;
                    o_last  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.need_div = (w_status == STS_WRITE) && (w_mode == MODE_CHS);
    assign o_sts.last     = o_last;

endmodule

FILE: rtl/core/ata_taskfile_command_issuer_top.sv
// a request transfer leads to the check state, which registers status, mode and chs
// quotient, then to the first register write; a chs request passes the remainder
// state between the two, to form the sector remainder; one request at a time,
// results leave one per cycle while the output is not stalled, set by the write sequencer
// reset (i_rst_n, synchronous, active low) clears all configuration to zero and idles
module ata_taskfile_command_issuer_top
    import ataci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_direction,
    input  logic [1:0]  i_drive_index,
    input  logic [31:0] i_block_address,
    input  logic [7:0]  i_sector_count,
    // register write channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_channel_sel,
    output logic [3:0]  o_port,
    output logic [7:0]  o_wdata,
    output logic        o_last
);

    // controller and datapath talk only through these two groups
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: idle, check, chs remainder, then one transfer per write
    ataci_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // config registers, request capture, range check, chs split, write decode
    ataci_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_direction     (i_direction),
        .i_drive_index   (i_drive_index),
        .i_block_address (i_block_address),
        .i_sector_count  (i_sector_count),
        .o_status        (o_status),
        .o_channel_sel   (o_channel_sel),
        .o_port          (o_port),
        .o_wdata         (o_wdata),
        .o_last          (o_last)
    );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    import ataci_pkg::*;

    // one request on the input channel
    typedef struct {
        logic        write;
        logic [1:0]  drive;
        logic [31:0] lba;
        logic [7:0]  count;
    } t_request;

    // one task-file register write (or reject) on the output channel
    typedef struct {
        logic [1:0] status;
        logic       chan;
        logic [3:0] port;
        logic [7:0] data;
        logic       last;
    } t_tf_write;

    localparam int unsigned SECTORS_PER_CYL = 16 * SECT_PER_TRACK;
    // longest request latency is the chs path, keep some margin
    localparam int          SETTLE_CYCLES   = 40;

    // clock, reset and all block inputs start at known values
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [2:0]  cfg_index    = CFG_PRESENT;
    logic [31:0] cfg_wdata    = '0;
    logic        in_valid     = 1'b0;
    logic        direction    = 1'b0;
    logic [1:0]  drive_index  = '0;
    logic [31:0] block_address = '0;
    logic [7:0]  sector_count = '0;
    logic        out_stall    = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  status;
    logic        channel_sel;
    logic [3:0]  port;
    logic [7:0]  wdata;
    logic        last;

    // local copy of the drive configuration, updated as registers are written
    logic [3:0]  present_mask;
    logic [3:0]  atapi_mask;
    logic [3:0]  lba_capable_mask;
    logic [31:0] drive_capacity [4];

    t_request    pending_requests [$];
    t_request    in_flight;
    t_tf_write   expected_writes [$];

    // idle / stall percentages, changed per phase
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    int          errors         = 0;
    int          writes_checked = 0;
    int          lba28_issued   = 0;
    int          lba48_issued   = 0;
    int          chs_issued     = 0;
    int          rejected       = 0;

    ata_taskfile_command_issuer_top DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_direction    (direction),
        .i_drive_index  (drive_index),
        .i_block_address(block_address),
        .i_sector_count (sector_count),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_channel_sel  (channel_sel),
        .o_port         (port),
        .o_wdata        (wdata),
        .o_last         (last)
    );

    // period of 2 time units
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void add_write(logic [1:0] sts, logic chan, logic [3:0] prt,
                                      logic [7:0] data, logic fin);
        t_tf_write w;
        w.status = sts;
        w.chan   = chan;
        w.port   = prt;
        w.data   = data;
        w.last   = fin;
        expected_writes.push_back(w);
    endfunction

    // works out the register writes (or the single reject) that a request causes
    function automatic void predict_taskfile_writes(t_request rq);
        logic [3:0]  drive_bit;
        logic        chan;
        logic        slave;
        logic [32:0] end_sector;
        logic        use_lba48;
        logic        use_chs;
        int unsigned base;
        int unsigned cyl;
        int unsigned head;
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [7:0]  a2;
        logic [7:0]  devsel;
        logic [7:0]  cmd;
        logic [3:0]  hob_ports [4];
        logic [7:0]  hob_data [4];

        drive_bit  = 4'b0001 << rq.drive;
        chan       = rq.drive[1];
        slave      = rq.drive[0];
        end_sector = {1'b0, rq.lba} + {25'b0, rq.count};

        // reject checks: absent drive first, then atapi, then the 33-bit range
        if (int'(rq.drive) >= NUM_DRIVES || (present_mask & drive_bit) == 0) begin
            add_write(STS_NO_DRIVE, chan, 4'd0, 8'd0, 1'b1);
            rejected++;
            return;
        end
        if ((atapi_mask & drive_bit) != 0) begin
            add_write(STS_ATAPI, chan, 4'd0, 8'd0, 1'b1);
            rejected++;
            return;
        end
        if (end_sector > {1'b0, drive_capacity[rq.drive]}) begin
            add_write(STS_RANGE, chan, 4'd0, 8'd0, 1'b1);
            rejected++;
            return;
        end

        use_lba48 = (rq.lba >= LBA48_START);
        use_chs   = !use_lba48 && (lba_capable_mask & drive_bit) == 0;
        if (use_chs) begin
            // sector is 1-based, cylinder keeps only its low 16 bits
            base = rq.lba - rq.lba % SECT_PER_TRACK;
            a0   = 8'(rq.lba % SECT_PER_TRACK + 1);
            cyl  = (base / SECTORS_PER_CYL) & 32'h0000_FFFF;
            head = (base % SECTORS_PER_CYL) / SECT_PER_TRACK;
            a1   = cyl[7:0];
            a2   = cyl[15:8];
            chs_issued++;
        end else begin
            a0   = rq.lba[7:0];
            a1   = rq.lba[15:8];
            a2   = rq.lba[23:16];
            head = use_lba48 ? 0 : rq.lba[27:24];
            if (use_lba48)
                lba48_issued++;
            else
                lba28_issued++;
        end

        devsel = (use_chs ? DEVSEL_CHS : DEVSEL_LBA) | {3'b000, slave, 4'(head)};
        if (use_lba48)
            cmd = rq.write ? CMD_WRITE_EXT : CMD_READ_EXT;
        else
            cmd = rq.write ? CMD_WRITE : CMD_READ;

        add_write(STS_WRITE, chan, PORT_CTRL, CTRL_NIEN, 1'b0);
        add_write(STS_WRITE, chan, PORT_DEVSEL, devsel, 1'b0);
        if (use_lba48) begin
            // high-order bytes, each bracketed by the hob bit in device control
            hob_ports = '{PORT_COUNT, PORT_LBA_LO, PORT_LBA_MD, PORT_LBA_HI};
            hob_data  = '{8'd0, rq.lba[31:24], 8'd0, 8'd0};
            for (int i = 0; i < 4; i++) begin
                add_write(STS_WRITE, chan, PORT_CTRL, CTRL_HOB | CTRL_NIEN, 1'b0);
                add_write(STS_WRITE, chan, hob_ports[i], hob_data[i], 1'b0);
                add_write(STS_WRITE, chan, PORT_CTRL, CTRL_NIEN, 1'b0);
            end
        end
        add_write(STS_WRITE, chan, PORT_COUNT, rq.count, 1'b0);
        add_write(STS_WRITE, chan, PORT_LBA_LO, a0, 1'b0);
        add_write(STS_WRITE, chan, PORT_LBA_MD, a1, 1'b0);
        add_write(STS_WRITE, chan, PORT_LBA_HI, a2, 1'b0);
        add_write(STS_WRITE, chan, PORT_CMD, cmd, 1'b1);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: ERROR %s expected 0x%0h got 0x%0h", $time, name, want, got);
        end
    endfunction

    // request driver: presents queued requests, idles at random between them,
    // and hands each accepted transfer to the predictor
    always @(posedge clk) begin : request_driver
        logic busy;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                predict_taskfile_writes(in_flight);
            busy = in_valid && in_stall;
            if (!busy) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = pending_requests.pop_front();
                    in_valid      <= 1'b1;
                    direction     <= in_flight.write;
                    drive_index   <= in_flight.drive;
                    block_address <= in_flight.lba;
                    sector_count  <= in_flight.count;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // write monitor: checks every accepted output transfer against the oldest
    // expected register write, stalls at random
    always @(posedge clk) begin : write_monitor
        t_tf_write want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                writes_checked++;
                if (expected_writes.size() == 0) begin
                    errors++;
                    $display("%0t: ERROR unexpected write: status %0d port %0d data 0x%02h",
                             $time, status, port, wdata);
                end else begin
                    want = expected_writes.pop_front();
                    check_field("status", want.status, status);
                    check_field("channel_sel", want.chan, channel_sel);
                    check_field("port", want.port, port);
                    check_field("wdata", want.data, wdata);
                    check_field("last", want.last, last);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PRESENT:   present_mask     = value[3:0];
            CFG_ATAPI:     atapi_mask       = value[3:0];
            CFG_LBA_CAP:   lba_capable_mask = value[3:0];
            CFG_SECTORS_0: drive_capacity[0] = value;
            CFG_SECTORS_1: drive_capacity[1] = value;
            CFG_SECTORS_2: drive_capacity[2] = value;
            CFG_SECTORS_3: drive_capacity[3] = value;
            default: ;
        endcase
    endtask

    task automatic configure_drives(input logic [3:0] present, input logic [3:0] atapi,
                                    input logic [3:0] lba_cap, input logic [31:0] cap0,
                                    input logic [31:0] cap1, input logic [31:0] cap2,
                                    input logic [31:0] cap3);
        write_reg(CFG_PRESENT, {28'd0, present});
        write_reg(CFG_ATAPI, {28'd0, atapi});
        write_reg(CFG_LBA_CAP, {28'd0, lba_cap});
        write_reg(CFG_SECTORS_0, cap0);
        write_reg(CFG_SECTORS_1, cap1);
        write_reg(CFG_SECTORS_2, cap2);
        write_reg(CFG_SECTORS_3, cap3);
    endtask

    task automatic queue_request(input logic wr, input logic [1:0] drv,
                                 input logic [31:0] lba, input logic [7:0] cnt);
        t_request rq;
        rq.write = wr;
        rq.drive = drv;
        rq.lba   = lba;
        rq.count = cnt;
        pending_requests.push_back(rq);
    endtask

    // sender holds back until the queue is empty and every write has come out,
    // then the block gets time to settle before any register write
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // capacity mix: full range, random, below the lba48 threshold, tiny
    function automatic logic [31:0] random_capacity();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return 32'hFFFF_FFFF;
        else if (pick < 60)
            return $urandom;
        else if (pick < 85)
            return $urandom_range(32'h0FFF_FFFF, 0);
        else
            return $urandom_range(300, 0);
    endfunction

    // mostly requests that pass the checks, with lba28/lba48/chs all reachable,
    // plus boundary hits around the capacity and fully random noise
    function automatic t_request random_request();
        t_request    rq;
        int unsigned pick;
        logic [31:0] cap;
        logic [31:0] room;
        rq.write = 1'($urandom_range(1));
        rq.drive = 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 10)
            rq.count = 8'd0;
        else if (pick < 20)
            rq.count = 8'hFF;
        else
            rq.count = 8'($urandom);
        cap  = drive_capacity[rq.drive];
        room = cap - rq.count;
        pick = $urandom_range(99);
        if (pick < 55 && cap >= rq.count) begin
            if ($urandom_range(1))
                rq.lba = $urandom_range(room < 32'h0FFF_FFFF ? room : 32'h0FFF_FFFF, 0);
            else
                rq.lba = $urandom_range(room, 0);
        end else if (pick < 70) begin
            // just below, at and just above the end of the drive
            rq.lba = room + $urandom_range(2) - 1;
        end else if (pick < 85) begin
            // low addresses, dense in chs track and cylinder boundaries
            rq.lba = $urandom_range(3000, 0);
        end else begin
            rq.lba = $urandom;
        end
        return rq;
    endfunction

    // stimulus sequencer: directed requests first, then random phases under
    // the four idle / stall mixes
    initial begin : stimulus
        int send_mix [4];
        int recv_mix [4];
        present_mask     = '0;
        atapi_mask       = '0;
        lba_capable_mask = '0;
        drive_capacity   = '{32'd0, 32'd0, 32'd0, 32'd0};
        send_mix = '{0, 56, 0, 21};
        recv_mix = '{0, 0, 56, 21};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // after reset no drive is present: every request bounces as no drive
        for (int d = 0; d < NUM_DRIVES; d++)
            queue_request(1'(d), 2'(d), 32'hFFFF_FFFF, 8'(d));
        wait_until_drained();

        // drive 0 lba, drive 1 chs only, drive 2 absent, drive 3 atapi
        configure_drives(4'b1011, 4'b1000, 4'b0001,
                         32'hFFFF_FFFF, 32'h1000_0010, 32'h0000_1234, 32'd0);
        queue_request(1'b0, 2'd0, 32'h0000_0000, 8'd0);     // zero count goes out as is
        queue_request(1'b1, 2'd0, 32'h0FFF_FFFF, 8'hFF);    // top of lba28, head 15
        queue_request(1'b0, 2'd0, 32'h1000_0000, 8'd1);     // first lba48 address
        queue_request(1'b1, 2'd0, 32'hFFFF_FF00, 8'hFF);    // lba48 ending on capacity
        queue_request(1'b0, 2'd0, 32'hFFFF_FFFF, 8'd1);     // sum overflows 32 bits
        queue_request(1'b1, 2'd0, 32'hFFFF_FFFF, 8'd0);     // last sector, zero count
        queue_request(1'b0, 2'd1, 32'd0, 8'd1);             // chs origin
        queue_request(1'b1, 2'd1, 32'd62, 8'd2);            // last sector of a track
        queue_request(1'b0, 2'd1, 32'd63, 8'd3);            // next head
        queue_request(1'b0, 2'd1, 32'd1007, 8'd1);          // last sector of a cylinder
        queue_request(1'b1, 2'd1, 32'd1008, 8'd4);          // next cylinder
        queue_request(1'b0, 2'd1, 32'h0FFF_FFFF, 8'd1);     // cylinder beyond 16 bits
        queue_request(1'b1, 2'd1, 32'h1000_0000, 8'd16);    // lba48 on a chs drive, at end
        queue_request(1'b0, 2'd1, 32'h1000_0000, 8'd17);    // one sector past the end
        queue_request(1'b0, 2'd2, 32'd0, 8'd1);             // absent drive
        queue_request(1'b1, 2'd3, 32'hFFFF_FFFF, 8'hFF);    // atapi skips the range check
        wait_until_drained();

        // drives 0 to 2 have zero capacity, where only an empty request at block 0 fits; drive 3 spans the full range
        configure_drives(4'b1111, 4'b0000, 4'b0101, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        queue_request(1'b0, 2'd0, 32'd0, 8'd0);
        queue_request(1'b1, 2'd1, 32'd0, 8'd0);
        queue_request(1'b0, 2'd2, 32'd0, 8'd1);
        queue_request(1'b1, 2'd3, 32'h5555_5555, 8'hAA);
        wait_until_drained();

        // every drive atapi
        configure_drives(4'b1111, 4'b1111, 4'b1111, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_request(1'b0, 2'd2, 32'd0, 8'd0);
        wait_until_drained();

        for (int m = 0; m < 4; m++) begin
            send_idle_pct  = send_mix[m];
            recv_stall_pct = recv_mix[m];
            configure_drives($urandom_range(3) != 0 ? 4'hF : 4'($urandom),
                             $urandom_range(3) == 0 ? 4'($urandom) : 4'h0,
                             4'($urandom),
                             random_capacity(), random_capacity(),
                             random_capacity(), random_capacity());
            // two bursts, the sender waits for every write between them
            for (int b = 0; b < 2; b++) begin
                for (int n = 0; n < 51; n++)
                    pending_requests.push_back(random_request());
                wait_until_drained();
            end
        end

        $display("covered %0d register writes: %0d lba28, %0d lba48, %0d chs requests",
                 writes_checked, lba28_issued, lba48_issued, chs_issued);
        $display("plus %0d rejected requests, under four sender/receiver idle mixes",
                 rejected);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hard limit, far above the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("timeout with %0d register writes still outstanding",
                 expected_writes.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: ata_taskfile_command_issuer_top.f
rtl/core/ataci_pkg.sv
rtl/core/ataci_ctrl.sv
rtl/core/ataci_dp.sv
rtl/core/ata_taskfile_command_issuer_top.sv
tb/sv/tb_top.sv
